// File: hdl/sha256_stream_hasher_defines.svh
// Assertion macros for the SHA-256 stream hasher.
// Synthesis builds define SYNTH, which turns every use into nothing.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

`ifndef SYNTH

// Consequent checked in the same cycle as the antecedent.
`define SHS_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("shs assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("shs assertion failed");

`else

`define SHS_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons)
`define SHS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// File: hdl/shs_pkg.sv
`timescale 1ns / 1ps

package shs_pkg;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  localparam logic [31:0] INIT_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Strobes from the sequencer to the schedule and round units.
  typedef struct packed {
    logic shift_byte;  // push one byte into the block window
    logic step;        // run one compression round
    logic load_work;   // copy chaining value into working vars
    logic add_cv;      // fold working vars into chaining value
    logic init_cv;     // reload initial hash words
  } shs_ctrl_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// File: hdl/shs_sched.sv
`timescale 1ns / 1ps

// 16-word window: bytes shift in big-endian while filling,
// then words shift out one per round with the expanded word appended.
module shs_sched (
  input  logic              clk,
  input  shs_pkg::shs_ctrl_t ctrl,
  input  logic [7:0]        byte_val,
  output logic [31:0]       w_cur
);
  import shs_pkg::*;

  logic [511:0] win;
  logic [31:0]  w_new;

  // word k of the window sits at win[511-32k -: 32]
  assign w_cur = win[511:480];
  assign w_new = small_sigma1(win[63:32]) + win[223:192]
               + small_sigma0(win[479:448]) + win[511:480];

  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      win <= {win[503:0], byte_val};
    end else if (ctrl.step) begin
      win <= {win[479:0], w_new};
    end
  end

endmodule

// File: hdl/shs_round.sv
`timescale 1ns / 1ps

// Working variables a..h, one round per step, and the chaining value.
module shs_round (
  input  logic               clk,
  input  logic               rst,
  input  shs_pkg::shs_ctrl_t ctrl,
  input  logic [31:0]        w_cur,
  input  logic [5:0]         round,
  output logic [7:0][31:0]   cv
);
  import shs_pkg::*;

  logic [7:0][31:0] work;  // work[0] = a ... work[7] = h
  logic [31:0]      t1;
  logic [31:0]      t2;

  always_comb begin
    t1 = work[7] + big_sigma1(work[4])
       + ((work[4] & work[5]) ^ (~work[4] & work[6]))
       + ROUND_K[round] + w_cur;
    t2 = big_sigma0(work[0])
       + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_work) begin
      work <= cv;
    end else if (ctrl.step) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init_cv) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= INIT_WORDS[i];
      end
    end else if (ctrl.add_cv) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= cv[i] + work[i];
      end
    end
  end

endmodule

// File: hdl/sha256_stream_hasher.sv
// SHA-256 over a byte stream, one input word per byte. A start word reloads the
// initial hash and clears the counts; a data word adds one byte; a finish word
// pads the message, compresses the last block(s) and returns the digest as eight
// 32-bit words, word_index 0 (most significant) through 7, last set on word 7.
// A data or finish word after the digest has been produced returns one word with
// status 1, digest_word 0, word_index 0 and last 1, and changes nothing; a kind
// of 3 is taken and ignored. Data bytes are taken while the block is idle, and
// the byte that completes a 64-byte block starts a compression: 64 rounds on
// the single round unit, then a fold into the chaining value, and no further
// byte is taken until that is done. A finish pushes padding through the same
// byte path at one byte per cycle (9 to 72 pad bytes) with one or two
// compressions, then offers one digest word per cycle as the consumer takes
// them. item_ready is low throughout that work.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        status,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);
  import shs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_PAD      = 5'b00010,
    ST_COMPRESS = 5'b00100,
    ST_ADD      = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_t;

  state_t           state;
  logic [5:0]       fill;        // bytes held in the current block
  logic [63:0]      msg_bytes;   // wraps mod 2^64
  logic             finished;
  logic [5:0]       round;
  logic             pad_first;   // 0x80 marker still to go
  logic             len_phase;   // emitting the length field
  logic             pad_active;  // a finish is in progress
  logic             final_blk;   // block under compression carries the length
  logic [63:0]      len_shift;   // bit length, top byte goes next
  logic [2:0]       emit_idx;
  logic             accept;
  logic             out_free;
  logic             out_load;    // output register takes a new word this cycle
  logic [7:0]       byte_val;
  logic [31:0]      w_cur;
  logic [7:0][31:0] cv;
  shs_ctrl_t        ctrl;

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == ST_IDLE) && out_free;
  assign accept     = item_valid && item_ready;
  assign out_load   = (accept && finished && ((kind == KIND_DATA) || (kind == KIND_FINISH)))
                    || ((state == ST_EMIT) && out_free);

  // Sequencer strobes and the byte fed into the block window
  always_comb begin
    ctrl     = '0;
    byte_val = data_byte;
    case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_START)) begin
          ctrl.init_cv = 1'b1;
        end
        if (accept && (kind == KIND_DATA) && !finished) begin
          ctrl.shift_byte = 1'b1;
          ctrl.load_work  = (fill == LAST_BYTE);
        end
      end
      ST_PAD: begin
        ctrl.shift_byte = 1'b1;
        ctrl.load_work  = (fill == LAST_BYTE);
        if (pad_first) begin
          byte_val = PAD_MARK;
        end else if (len_phase || (fill == LEN_OFFSET)) begin
          byte_val = len_shift[63:56];
        end else begin
          byte_val = 8'h00;
        end
      end
      ST_COMPRESS: begin
        ctrl.step = 1'b1;
      end
      ST_ADD: begin
        ctrl.add_cv = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      msg_bytes    <= '0;
      finished     <= 1'b0;
      round        <= '0;
      pad_first    <= 1'b0;
      len_phase    <= 1'b0;
      pad_active   <= 1'b0;
      final_blk    <= 1'b0;
      emit_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_START: begin
                fill      <= '0;
                msg_bytes <= '0;
                finished  <= 1'b0;
              end
              KIND_DATA, KIND_FINISH: begin
                if (finished) begin
                  // rejection: single word, state untouched
                  status       <= 1'b1;
                  digest_word  <= '0;
                  word_index   <= '0;
                  last         <= 1'b1;
                end else if (kind == KIND_DATA) begin
                  fill      <= fill + 6'd1;
                  msg_bytes <= msg_bytes + 64'd1;
                  if (fill == LAST_BYTE) begin
                    state     <= ST_COMPRESS;
                    round     <= '0;
                    final_blk <= 1'b0;
                  end
                end else begin
                  state      <= ST_PAD;
                  pad_first  <= 1'b1;
                  len_phase  <= 1'b0;
                  pad_active <= 1'b1;
                  len_shift  <= {msg_bytes[60:0], 3'b000};
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          fill      <= fill + 6'd1;
          if (!pad_first && (len_phase || (fill == LEN_OFFSET))) begin
            len_phase <= 1'b1;
            len_shift <= {len_shift[55:0], 8'h00};
          end
          if (fill == LAST_BYTE) begin
            state     <= ST_COMPRESS;
            round     <= '0;
            final_blk <= len_phase;
          end
        end
        ST_COMPRESS: begin
          round <= round + 6'd1;
          if (round == LAST_ROUND) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (final_blk) begin
            state      <= ST_EMIT;
            emit_idx   <= '0;
            finished   <= 1'b1;
            pad_active <= 1'b0;
            len_phase  <= 1'b0;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            status       <= 1'b0;
            digest_word  <= cv[emit_idx];
            word_index   <= emit_idx;
            last         <= (emit_idx == LAST_WORD);
            emit_idx     <= emit_idx + 3'd1;
            if (emit_idx == LAST_WORD) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  shs_sched u_sched (
    .clk      (clk),
    .ctrl     (ctrl),
    .byte_val (byte_val),
    .w_cur    (w_cur)
  );

  shs_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .w_cur (w_cur),
    .round (round),
    .cv    (cv)
  );

  // Compression leaves the last round (63) for the add state.
  `SHS_ASSERT_NEXT(a_round_to_add, clk, rst,
    (state == ST_COMPRESS) && (round == LAST_ROUND), state == ST_ADD)
  // A digest word only goes out for a finished message.
  `SHS_ASSERT_SAME(a_digest_finished, clk, rst, result_valid && !status, finished)
  // The 64th data byte starts a compression at round 0.
  `SHS_ASSERT_NEXT(a_block_full, clk, rst,
    accept && (kind == KIND_DATA) && !finished && (fill == LAST_BYTE),
    (state == ST_COMPRESS) && (round == 6'd0))

endmodule

// File: sim/sha256_digest_checker.sv
`timescale 1ns / 1ps

module sha256_digest_checker
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic        status,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic        status;
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t expected_words[$];

  // running hash of the message seen so far
  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  fill;
  logic [63:0] byte_count;
  bit          digest_done;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = INIT_WORDS[i];
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    fill        = '0;
    byte_count  = '0;
    digest_done = 1'b0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, ch, mj;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + ROUND_K[r] + w[r];
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  // pad, compress the tail block(s) and queue the eight digest words
  function automatic void finish_digest();
    logic [63:0] bit_len;
    int p;
    digest_word_t dw;
    bit_len = byte_count << 3;
    p = fill;
    block_bytes[p] = PAD_MARK;
    p++;
    if (p > LEN_OFFSET) begin
      for (; p < 64; p++) block_bytes[p] = 8'h00;
      compress_block();
      p = 0;
    end
    for (; p < LEN_OFFSET; p++) block_bytes[p] = 8'h00;
    for (int i = 0; i < 8; i++) block_bytes[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    fill        = '0;
    digest_done = 1'b1;
    for (int i = 0; i < 8; i++) begin
      dw.status = 1'b0;
      dw.word   = hash_state[i];
      dw.index  = 3'(i);
      dw.last   = (i == 7);
      expected_words.push_back(dw);
    end
  endfunction

  function automatic void absorb_word(input logic [1:0] k, input logic [7:0] b);
    digest_word_t rej;
    rej = '{status: 1'b1, word: 32'h0, index: 3'd0, last: 1'b1};
    if (k == KIND_START) begin
      restart_hash();
    end else if (k == KIND_DATA || k == KIND_FINISH) begin
      if (digest_done) begin
        expected_words.push_back(rej);
      end else if (k == KIND_DATA) begin
        block_bytes[fill] = b;
        byte_count = byte_count + 64'd1;
        if (fill == LAST_BYTE) begin
          compress_block();
          fill = '0;
        end else begin
          fill = fill + 6'd1;
        end
      end else begin
        finish_digest();
      end
    end
  endfunction

  function automatic bit field_ok(input string name, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    digest_word_t exp_w;
    bit ok;
    if (rst) begin
      restart_hash();
      expected_words.delete();
    end else begin
      // compare first: a result never stems from a word taken at the same edge
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0b word %0h index %0d last %0b",
                   $time, status, digest_word, word_index, last);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          ok = field_ok("status", 32'(exp_w.status), 32'(status));
          ok = field_ok("digest_word", exp_w.word, digest_word) && ok;
          ok = field_ok("word_index", 32'(exp_w.index), 32'(word_index)) && ok;
          ok = field_ok("last", 32'(exp_w.last), 32'(last)) && ok;
          if (!ok) fail_count++;
        end
      end
      if (item_valid && item_ready) absorb_word(kind, data_byte);
    end
    outstanding = expected_words.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import shs_pkg::*;

  // kind 3 has no name in the package; the block takes it and drops it
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // cycles the receiver holds off once, long enough to back up the input
  localparam int HOLD_CYCLES = 800;
  // no-progress limit: longest finish plus the hold-off, with margin
  localparam int QUIET_LIMIT = 5000;
  // drain time after the last digest word, covers a full padded finish
  localparam int TAIL_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        result_valid;
  logic        result_ready;
  logic        status;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  int fail_count;
  int outstanding;

  // stimulus controls; gaps_on and hold_off_req are shared with the receiver process
  bit gaps_on;
  bit hold_off_req;
  int words_sent;

  sha256_stream_hasher i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last         (last)
  );

  sha256_digest_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last         (last),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one word from a falling edge and hold it until taken. Returns on the
  // falling edge after acceptance, so the next word can follow back to back.
  // An optional gap (valid low) goes in front of the word.
  task automatic send_word(input logic [1:0] k, input logic [7:0] b);
    if (gaps_on && $urandom_range(99) < 9) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    data_byte  <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (k != KIND_UNUSED) words_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte();
    send_word(KIND_DATA, 8'($urandom_range(255)));
  endtask

  // One message of random content plus the usual abuse: stray unused kinds,
  // an occasional restart midway, a message left unfinished, and data or a
  // second finish after the digest (each of those is rejected by the block).
  task automatic send_message(input int len);
    int cut;
    send_word(KIND_START, 8'($urandom_range(255)));
    if ($urandom_range(9) == 0) begin
      // broken prefix, thrown away by a restart
      cut = $urandom_range(1, 5);
      repeat (cut) send_byte();
      send_word(KIND_START, 8'($urandom_range(255)));
    end
    repeat (len) begin
      if ($urandom_range(99) < 5) send_word(KIND_UNUSED, 8'($urandom_range(255)));
      send_byte();
    end
    if ($urandom_range(9) != 0) begin
      send_word(KIND_FINISH, 8'($urandom_range(255)));
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(1)) send_byte();
          else send_word(KIND_FINISH, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  // receiver: random ready, plus one long hold-off on request
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        result_ready <= !gaps_on || ($urandom_range(99) >= 9);
      end
    end
  end

  // watchdog: any stretch with no handshake on either side that runs too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL sha256_stream_hasher");
    $finish;
  end

  initial begin
    int msg_no;
    int len;
    rst          = 1'b1;
    item_valid   = 1'b0;
    kind         = KIND_START;
    data_byte    = 8'h00;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    words_sent   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part.
    // Finish straight out of reset: digest of the empty message.
    send_word(KIND_FINISH, 8'h00);
    // After a digest, data and a second finish are rejected; unused kind is silent.
    send_word(KIND_DATA, 8'hff);
    send_word(KIND_FINISH, 8'hff);
    send_word(KIND_UNUSED, 8'hff);
    // "abc", with an unused kind in the middle of the message
    send_word(KIND_START, 8'h00);
    send_word(KIND_DATA, 8'h61);
    send_word(KIND_DATA, 8'h62);
    send_word(KIND_UNUSED, 8'h00);
    send_word(KIND_DATA, 8'h63);
    send_word(KIND_FINISH, 8'h00);
    // byte extremes
    send_word(KIND_START, 8'hff);
    send_word(KIND_DATA, 8'h00);
    send_word(KIND_DATA, 8'hff);
    send_word(KIND_DATA, 8'haa);
    send_word(KIND_DATA, 8'h55);
    send_word(KIND_FINISH, 8'haa);
    // start in the middle of a message drops what came before
    send_word(KIND_START, 8'h00);
    send_word(KIND_DATA, 8'h5a);
    send_word(KIND_DATA, 8'ha5);
    send_word(KIND_START, 8'h00);
    send_word(KIND_DATA, 8'h01);
    send_word(KIND_FINISH, 8'h00);

    // Random part. The first messages sit on the padding boundaries: 55 bytes
    // fit the length in the same block, 56 push it into a second block, 64 is
    // an exact block. Messages 1 and 2 run with no gaps on either side.
    words_sent = 0;
    msg_no     = 0;
    while (words_sent < 250) begin
      gaps_on = !(msg_no == 1 || msg_no == 2);
      case (msg_no)
        0: len = 55;
        1: len = 56;
        2: len = 64;
        default: begin
          if ($urandom_range(9) == 0) begin
            case ($urandom_range(5))
              0: len = 57;
              1: len = 63;
              2: len = 65;
              3: len = 119;
              4: len = 120;
              default: len = 55;
            endcase
          end else begin
            len = $urandom_range(0, 12);
          end
        end
      endcase
      // one long receiver hold-off: the digest backs up and the next message
      // waits at the input
      if (msg_no == 4) hold_off_req = 1'b1;
      send_message(len);
      msg_no++;
    end
    item_valid <= 1'b0;
    gaps_on = 1'b1;

    // drain, then let any stray output show up
    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("PASS sha256_stream_hasher");
    end else begin
      $display("FAIL sha256_stream_hasher");
    end
    $finish;
  end

endmodule
